// ===== sv/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg
// types, sizes and codes shared by the keyed record table
// ----------------------------------------------------------------------------
`default_nettype none

package krt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DESC_W      = 160;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LIST   = 2'd1,
        ACT_SORT   = 2'd2,
        ACT_DELETE = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_INSERTED  = 4'd0,
        ST_DUPLICATE = 4'd1,
        ST_FULL      = 4'd2,
        ST_DELETED   = 4'd3,
        ST_NOT_FOUND = 4'd4,
        ST_EMPTY     = 4'd5,
        ST_SORTED    = 4'd6,
        ST_LISTED    = 4'd7,
        ST_IGNORED   = 4'd8
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_DEL_RD,
        S_DEL_WR,
        S_LIST_RD,
        S_LIST_OUT,
        S_SRT_RDI,
        S_SRT_LDI,
        S_SRT_RDJ,
        S_SRT_CMP,
        S_SRT_WRI,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]         action;
        logic [30:0]        code;
        logic signed [31:0] stock;
        logic [30:0]        price_cents;
        logic [4:0]         day;
        logic [3:0]         month;
        logic [13:0]        year;
        logic [63:0]        desc_first;
        logic [63:0]        desc_middle;
        logic [31:0]        desc_tail;
    } t_cmd;

    typedef struct packed {
        logic [3:0]         status;
        logic [4:0]         entry_count;
        logic               last;
        logic [30:0]        rec_code;
        logic signed [31:0] rec_stock;
        logic [30:0]        rec_price_cents;
        logic [4:0]         rec_day;
        logic [3:0]         rec_month;
        logic [13:0]        rec_year;
        logic [63:0]        rec_desc_first;
        logic [63:0]        rec_desc_middle;
        logic [31:0]        rec_desc_tail;
    } t_res;

    typedef struct packed {
        logic [30:0]        code;
        logic signed [31:0] stock;
        logic [30:0]        price_cents;
        logic [4:0]         day;
        logic [3:0]         month;
        logic [13:0]        year;
        logic [63:0]        desc_first;
        logic [63:0]        desc_middle;
        logic [31:0]        desc_tail;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

endpackage

`default_nettype wire

// ===== sv/krt_cmd_if.sv =====
// ----------------------------------------------------------------------------
// krt_cmd_if
// command channel: valid, ready and one command beat
// ----------------------------------------------------------------------------
`default_nettype none

interface krt_cmd_if;
    import krt_pkg::*;

    logic valid;
    logic ready;
    t_cmd payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/krt_res_if.sv =====
// ----------------------------------------------------------------------------
// krt_res_if
// result channel: valid, ready and one result beat
// ----------------------------------------------------------------------------
`default_nettype none

interface krt_res_if;
    import krt_pkg::*;

    logic valid;
    logic ready;
    t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/keyed_record_table_insert_delete_sort_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_record_table_insert_delete_sort_unit
// keyed product record table with insert, delete, list and exchange sort
// ----------------------------------------------------------------------------
// i_cmd carries one command beat (insert, list, sort or delete); o_res carries
// result beats, with last set on the final beat of each command. A list gives
// one beat per entry, or one beat on an empty table; other commands give one.
// Records sit in one ram of TABLE_DEPTH entries with registered read data,
// so each table read is used in the next cycle, by a check, load or write:
//   insert / delete search: a read and a code check per entry scanned
//   delete close-up: a read and a write per entry moved down
//   list: a read and a result beat per entry, the beat held while o_res stalls
//   sort: n(n-1)/2 read-compare steps, entry i read, loaded, written per pass
// A command is taken only while the controller is idle; a finished result may
// still be waiting in the output register at that point.
// Reset empties the table at once (entry count to zero) and drops any
// waiting beat. When o_res stalls, the controller runs on to its next result
// step and holds there; the output register keeps its beat until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_record_table_insert_delete_sort_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    krt_cmd_if.sink   i_cmd,
    krt_res_if.source o_res
);
    import krt_pkg::*;

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_i, n_i;
    t_rec             r_a, n_a;
    t_status          r_res_status, n_res_status;
    t_rec             r_res_rec, n_res_rec;
    logic             r_out_valid;
    t_res             r_out;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [REC_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [REC_W-1:0]  ram_rdata;

    t_rec  rd_rec;
    t_rec  new_rec;
    t_cmd  c;
    logic  cmd_fire;
    logic  out_free;
    logic  out_load;
    t_res  out_data;
    logic  greater;
    logic  code_hit;
    logic  idx_end;
    logic  idx_last;
    logic  del_more;
    logic  i_more;

    function automatic t_res to_res(input t_status st, input logic [CNT_W-1:0] cnt,
                                    input logic lst, input t_rec rec);
        t_res r;
        r.status          = st;
        r.entry_count     = 5'(cnt);
        r.last            = lst;
        r.rec_code        = rec.code;
        r.rec_stock       = rec.stock;
        r.rec_price_cents = rec.price_cents;
        r.rec_day         = rec.day;
        r.rec_month       = rec.month;
        r.rec_year        = rec.year;
        r.rec_desc_first  = rec.desc_first;
        r.rec_desc_middle = rec.desc_middle;
        r.rec_desc_tail   = rec.desc_tail;
        return r;
    endfunction

    krt_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    krt_desc_cmp u_cmp (
        .i_a_desc  ({r_a.desc_first, r_a.desc_middle, r_a.desc_tail}),
        .i_b_desc  ({rd_rec.desc_first, rd_rec.desc_middle, rd_rec.desc_tail}),
        .o_greater (greater)
    );

    assign rd_rec   = t_rec'(ram_rdata);
    assign c        = i_cmd.payload;
    assign cmd_fire = i_cmd.valid && i_cmd.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign code_hit = rd_rec.code == r_cmd.code;
    assign idx_end  = r_idx == r_count;
    assign idx_last = (r_idx + CNT_W'(1)) == r_count;
    assign del_more = (r_idx + CNT_W'(1)) < r_count;
    assign i_more   = (r_i + CNT_W'(2)) < r_count;

    assign new_rec.code        = r_cmd.code;
    assign new_rec.stock       = r_cmd.stock;
    assign new_rec.price_cents = r_cmd.price_cents;
    assign new_rec.day         = r_cmd.day;
    assign new_rec.month       = r_cmd.month;
    assign new_rec.year        = r_cmd.year;
    assign new_rec.desc_first  = r_cmd.desc_first;
    assign new_rec.desc_middle = r_cmd.desc_middle;
    assign new_rec.desc_tail   = r_cmd.desc_tail;

    assign i_cmd.ready   = r_state == S_IDLE;
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (cmd_fire) begin
                    case (t_action'(c.action))
                        ACT_INSERT: begin
                            if (c.code == '0 || r_count >= CNT_W'(TABLE_DEPTH)) begin
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_SRCH_RD;
                            end
                        end
                        ACT_LIST: begin
                            n_state = (r_count == '0) ? S_EMIT : S_LIST_RD;
                        end
                        ACT_SORT: begin
                            n_state = (r_count < CNT_W'(2)) ? S_EMIT : S_SRT_RDI;
                        end
                        default: begin
                            if (r_count == '0 || c.code == '0) begin
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_SRCH_RD;
                            end
                        end
                    endcase
                end
            end
            S_SRCH_RD: begin
                n_state = idx_end ? S_EMIT : S_SRCH_CHK;
            end
            S_SRCH_CHK: begin
                if (code_hit) begin
                    n_state = (r_cmd.action == ACT_INSERT) ? S_EMIT : S_DEL_RD;
                end else begin
                    n_state = S_SRCH_RD;
                end
            end
            S_DEL_RD: begin
                n_state = del_more ? S_DEL_WR : S_EMIT;
            end
            S_DEL_WR: begin
                n_state = S_DEL_RD;
            end
            S_LIST_RD: begin
                n_state = S_LIST_OUT;
            end
            S_LIST_OUT: begin
                if (out_free) begin
                    n_state = idx_last ? S_IDLE : S_LIST_RD;
                end
            end
            S_SRT_RDI: begin
                n_state = S_SRT_LDI;
            end
            S_SRT_LDI: begin
                n_state = S_SRT_RDJ;
            end
            S_SRT_RDJ: begin
                n_state = S_SRT_CMP;
            end
            S_SRT_CMP: begin
                n_state = idx_last ? S_SRT_WRI : S_SRT_RDJ;
            end
            S_SRT_WRI: begin
                n_state = i_more ? S_SRT_RDI : S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_cmd        = r_cmd;
        n_count      = r_count;
        n_idx        = r_idx;
        n_i          = r_i;
        n_a          = r_a;
        n_res_status = r_res_status;
        n_res_rec    = r_res_rec;
        ram_we       = 1'b0;
        ram_waddr    = r_idx[ADDR_W-1:0];
        ram_wdata    = REC_W'(r_a);
        ram_re       = 1'b0;
        ram_raddr    = r_idx[ADDR_W-1:0];
        out_load     = 1'b0;
        out_data     = to_res(r_res_status, r_count, 1'b1, r_res_rec);
        case (r_state)
            S_IDLE: begin
                if (cmd_fire) begin
                    n_cmd     = c;
                    n_idx     = '0;
                    n_i       = '0;
                    n_res_rec = '0;
                    case (t_action'(c.action))
                        ACT_INSERT: begin
                            n_res_status = (c.code == '0) ? ST_IGNORED : ST_FULL;
                        end
                        ACT_LIST: begin
                            n_res_status = ST_EMPTY;
                        end
                        ACT_SORT: begin
                            n_res_status = ST_SORTED;
                        end
                        default: begin
                            n_res_status = (r_count == '0) ? ST_EMPTY : ST_IGNORED;
                        end
                    endcase
                end
            end
            S_SRCH_RD: begin
                if (idx_end) begin
                    if (r_cmd.action == ACT_INSERT) begin
                        ram_we       = 1'b1;
                        ram_waddr    = r_count[ADDR_W-1:0];
                        ram_wdata    = REC_W'(new_rec);
                        n_count      = r_count + CNT_W'(1);
                        n_res_status = ST_INSERTED;
                        n_res_rec    = new_rec;
                    end else begin
                        n_res_status = ST_NOT_FOUND;
                    end
                end else begin
                    ram_re = 1'b1;
                end
            end
            S_SRCH_CHK: begin
                if (code_hit) begin
                    n_res_rec    = rd_rec;
                    n_res_status = (r_cmd.action == ACT_INSERT) ? ST_DUPLICATE : ST_DELETED;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_DEL_RD: begin
                if (del_more) begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(r_idx + CNT_W'(1));
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_DEL_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_idx     = r_idx + CNT_W'(1);
            end
            S_LIST_RD: begin
                ram_re = 1'b1;
            end
            S_LIST_OUT: begin
                out_data = to_res(ST_LISTED, r_count, idx_last, rd_rec);
                if (out_free) begin
                    out_load = 1'b1;
                    n_idx    = r_idx + CNT_W'(1);
                end
            end
            S_SRT_RDI: begin
                ram_re    = 1'b1;
                ram_raddr = r_i[ADDR_W-1:0];
            end
            S_SRT_LDI: begin
                n_a   = rd_rec;
                n_idx = r_i + CNT_W'(1);
            end
            S_SRT_RDJ: begin
                ram_re = 1'b1;
            end
            S_SRT_CMP: begin
                // swap: the held entry goes to j, entry j becomes the held one
                if (greater) begin
                    ram_we = 1'b1;
                    n_a    = rd_rec;
                end
                n_idx = r_idx + CNT_W'(1);
            end
            S_SRT_WRI: begin
                ram_we    = 1'b1;
                ram_waddr = r_i[ADDR_W-1:0];
                n_i       = r_i + CNT_W'(1);
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_idx        <= n_idx;
        r_i          <= n_i;
        r_a          <= n_a;
        r_res_status <= n_res_status;
        r_res_rec    <= n_res_rec;
        if (out_load) begin
            r_out <= out_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/krt_ram.sv =====
// ----------------------------------------------------------------------------
// krt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module krt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    input  wire logic                                         i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/krt_desc_cmp.sv =====
// ----------------------------------------------------------------------------
// krt_desc_cmp
// case-insensitive description compare, stopping at the first nul
// ----------------------------------------------------------------------------
`default_nettype none

module krt_desc_cmp (
    input  wire logic [krt_pkg::DESC_W-1:0] i_a_desc,
    input  wire logic [krt_pkg::DESC_W-1:0] i_b_desc,
    output logic                            o_greater
);
    import krt_pkg::*;

    localparam int NBYTES = DESC_W / 8;

    logic [DESC_W-1:0] key_a;
    logic [DESC_W-1:0] key_b;

    function automatic logic [7:0] fold(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b inside {[8'h41:8'h5A]}) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

    // fold to lower case and clear every byte after the first nul
    always_comb begin
        logic       nul_a;
        logic       nul_b;
        logic [7:0] fa;
        logic [7:0] fb;
        nul_a = 1'b0;
        nul_b = 1'b0;
        key_a = '0;
        key_b = '0;
        for (int k = 0; k < NBYTES; k++) begin
            fa = fold(i_a_desc[DESC_W-1-8*k -: 8]);
            fb = fold(i_b_desc[DESC_W-1-8*k -: 8]);
            key_a[DESC_W-1-8*k -: 8] = nul_a ? 8'h00 : fa;
            key_b[DESC_W-1-8*k -: 8] = nul_b ? 8'h00 : fb;
            if (fa == 8'h00) begin
                nul_a = 1'b1;
            end
            if (fb == 8'h00) begin
                nul_b = 1'b1;
            end
        end
    end

    assign o_greater = key_a > key_b;

endmodule

`default_nettype wire

// ===== verif/keyed_record_table_insert_delete_sort_unit_checker.sv =====
// ----------------------------------------------------------------------------
// keyed_record_table_insert_delete_sort_unit_checker
// Watches the command and result channels of the keyed record table. It keeps
// its own copy of the table, works out the result beats that each accepted
// command should give, and compares every accepted result beat with them in
// order. Mismatches and unexpected beats are counted.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module keyed_record_table_insert_delete_sort_unit_checker
    import krt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    krt_cmd_if        i_cmd,
    krt_res_if        i_res,
    output int        o_fail_count,
    output int        o_pending
);

    t_rec   table_rec[TABLE_DEPTH];
    int     entry_total;
    t_res   expected_beats[$];
    int     report_count;

    function automatic logic [7:0] desc_char(t_rec r, int k);
        logic [159:0] d;
        logic [7:0]   c;
        d = {r.desc_first, r.desc_middle, r.desc_tail};
        c = d[159 - 8 * k -: 8];
        if (c >= 8'h41 && c <= 8'h5a) begin
            c = c + 8'h20;
        end
        return c;
    endfunction

    function automatic bit desc_after(t_rec a, t_rec b);
        logic [7:0] x;
        logic [7:0] y;
        for (int k = 0; k < 20; k++) begin
            x = desc_char(a, k);
            y = desc_char(b, k);
            if (x != y) begin
                return x > y;
            end
            if (x == 8'd0) begin
                return 1'b0;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_res make_beat(t_status st, bit lst, bit has_rec, t_rec r);
        t_res b;
        b = '0;
        b.status      = st;
        b.entry_count = entry_total[4:0];
        b.last        = lst;
        if (has_rec) begin
            b.rec_code        = r.code;
            b.rec_stock       = r.stock;
            b.rec_price_cents = r.price_cents;
            b.rec_day         = r.day;
            b.rec_month       = r.month;
            b.rec_year        = r.year;
            b.rec_desc_first  = r.desc_first;
            b.rec_desc_middle = r.desc_middle;
            b.rec_desc_tail   = r.desc_tail;
        end
        return b;
    endfunction

    function automatic int find_code(logic [30:0] code);
        for (int i = 0; i < entry_total; i++) begin
            if (table_rec[i].code == code) begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic apply_command(t_cmd c);
        t_rec nr;
        t_rec tmp;
        t_rec none;
        int   pos;
        none = '0;
        case (t_action'(c.action))
            ACT_INSERT: begin
                if (c.code == '0) begin
                    expected_beats.push_back(make_beat(ST_IGNORED, 1, 0, none));
                end else if (entry_total >= TABLE_DEPTH) begin
                    expected_beats.push_back(make_beat(ST_FULL, 1, 0, none));
                end else begin
                    pos = find_code(c.code);
                    if (pos >= 0) begin
                        expected_beats.push_back(make_beat(ST_DUPLICATE, 1, 1,
                                                           table_rec[pos]));
                    end else begin
                        nr = '{c.code, c.stock, c.price_cents, c.day, c.month, c.year,
                               c.desc_first, c.desc_middle, c.desc_tail};
                        table_rec[entry_total] = nr;
                        entry_total++;
                        expected_beats.push_back(make_beat(ST_INSERTED, 1, 1, nr));
                    end
                end
            end
            ACT_LIST: begin
                if (entry_total == 0) begin
                    expected_beats.push_back(make_beat(ST_EMPTY, 1, 0, none));
                end else begin
                    for (int i = 0; i < entry_total; i++) begin
                        expected_beats.push_back(make_beat(ST_LISTED, i + 1 == entry_total,
                                                           1, table_rec[i]));
                    end
                end
            end
            ACT_SORT: begin
                for (int i = 0; i + 1 < entry_total; i++) begin
                    for (int j = i + 1; j < entry_total; j++) begin
                        if (desc_after(table_rec[i], table_rec[j])) begin
                            tmp          = table_rec[i];
                            table_rec[i] = table_rec[j];
                            table_rec[j] = tmp;
                        end
                    end
                end
                expected_beats.push_back(make_beat(ST_SORTED, 1, 0, none));
            end
            default: begin
                if (entry_total == 0) begin
                    expected_beats.push_back(make_beat(ST_EMPTY, 1, 0, none));
                end else if (c.code == '0) begin
                    expected_beats.push_back(make_beat(ST_IGNORED, 1, 0, none));
                end else begin
                    pos = find_code(c.code);
                    if (pos < 0) begin
                        expected_beats.push_back(make_beat(ST_NOT_FOUND, 1, 0, none));
                    end else begin
                        tmp = table_rec[pos];
                        for (int i = pos; i + 1 < entry_total; i++) begin
                            table_rec[i] = table_rec[i + 1];
                        end
                        entry_total--;
                        expected_beats.push_back(make_beat(ST_DELETED, 1, 1, tmp));
                    end
                end
            end
        endcase
    endtask

    task automatic check_beat(t_res got);
        t_res want;
        if (expected_beats.size() == 0) begin
            o_fail_count++;
            if (report_count < 10) begin
                report_count++;
                $display("unexpected result beat %h", got);
            end
            return;
        end
        want = expected_beats.pop_front();
        if (got !== want) begin
            o_fail_count++;
            if (report_count < 10) begin
                report_count++;
                $display("result mismatch: status exp %0d got %0d, count exp %0d got %0d",
                         want.status, got.status, want.entry_count, got.entry_count);
                $display("  last exp %0d got %0d, code exp %0d got %0d",
                         want.last, got.last, want.rec_code, got.rec_code);
                $display("  rest exp %h", want[REC_W-32:0]);
                $display("  rest got %h", got[REC_W-32:0]);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entry_total = 0;
            expected_beats.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                check_beat(i_res.payload);
            end
            if (i_cmd.valid && i_cmd.ready) begin
                apply_command(i_cmd.payload);
            end
        end
        o_pending = expected_beats.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        report_count = 0;
        entry_total  = 0;
    end

endmodule

`default_nettype wire

// ===== verif/keyed_record_table_insert_delete_sort_unit_test.sv =====
// ----------------------------------------------------------------------------
// keyed_record_table_insert_delete_sort_unit_test
// Drives directed and random commands into the keyed record table under
// several idle and stall patterns, including a long receiver hold-off, and
// gives the verdict from the checker's failure count and pending beat count.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module keyed_record_table_insert_delete_sort_unit_test;
    import krt_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_off;
    bit   done;
    logic [30:0] used_codes[$];

    krt_cmd_if cmd_ch ();
    krt_res_if res_ch ();

    keyed_record_table_insert_delete_sort_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source)
    );

    keyed_record_table_insert_delete_sort_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("keyed_record_table_insert_delete_sort_unit_test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_off) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [63:0] rand_text(bit mixed);
        logic [63:0] w;
        w = {$urandom, $urandom};
        if (!mixed) begin
            for (int k = 0; k < 8; k++) begin
                w[8*k +: 8] = 8'h41 + 8'($urandom_range(3)) + ($urandom_range(1) ? 8'h20 : 8'h0);
            end
        end
        return w;
    endfunction

    function automatic t_cmd make_cmd(t_action act, logic [30:0] code);
        t_cmd c;
        c.action      = act;
        c.code        = code;
        c.stock       = $urandom;
        c.price_cents = 31'($urandom);
        c.day         = 5'($urandom_range(1, 31));
        c.month       = 4'($urandom_range(1, 12));
        c.year        = 14'($urandom_range(0, 9999));
        c.desc_first  = rand_text($urandom_range(4) == 0);
        c.desc_middle = rand_text($urandom_range(4) == 0);
        c.desc_tail   = 32'(rand_text($urandom_range(4) == 0));
        if ($urandom_range(3) == 0) begin
            c.desc_first[31:0] = '0;
        end
        return c;
    endfunction

    task automatic send(t_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= c;
        @(posedge i_clk);
        while (!cmd_ch.ready) begin
            @(posedge i_clk);
        end
        if (c.action == ACT_INSERT) begin
            used_codes.push_back(c.code);
        end
    endtask

    task automatic send_idle_end;
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [30:0] pick_code;
        if (used_codes.size() > 0 && $urandom_range(2) != 0) begin
            return used_codes[$urandom_range(used_codes.size() - 1)];
        end
        return 31'($urandom_range(1, 40));
    endfunction

    task automatic random_phase(int n);
        t_cmd c;
        int   r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                c = make_cmd(ACT_INSERT, ($urandom_range(19) == 0) ? 31'd0 : pick_code());
            end else if (r < 60) begin
                c = make_cmd(ACT_LIST, 31'($urandom));
            end else if (r < 72) begin
                c = make_cmd(ACT_SORT, 31'($urandom));
            end else begin
                c = make_cmd(ACT_DELETE, ($urandom_range(19) == 0) ? 31'd0 : pick_code());
            end
            if ($urandom_range(9) == 0) begin
                c.code = 31'($urandom);
            end
            send(c);
        end
        send_idle_end();
    endtask

    initial begin
        t_cmd c;
        int   wait_cycles;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        i_rst_n        = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        res_ch.ready   = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table cases, extremes, full table, duplicates
        send(make_cmd(ACT_LIST, 31'd5));
        send(make_cmd(ACT_DELETE, 31'd0));
        send(make_cmd(ACT_DELETE, 31'd7));
        send(make_cmd(ACT_SORT, 31'd0));
        send(make_cmd(ACT_INSERT, 31'd0));
        c = make_cmd(ACT_INSERT, 31'h7fffffff);
        c.stock = 32'sh80000000; c.price_cents = '1; c.day = '1; c.month = '1;
        c.year = '1; c.desc_first = '1; c.desc_middle = '1; c.desc_tail = '1;
        send(c);
        c = make_cmd(ACT_INSERT, 31'd1);
        c.stock = 32'sh7fffffff; c.price_cents = '0; c.day = '0; c.month = '0;
        c.year = '0; c.desc_first = '0; c.desc_middle = '0; c.desc_tail = '0;
        send(c);
        send(make_cmd(ACT_INSERT, 31'd1));
        for (int k = 2; k <= 15; k++) begin
            send(make_cmd(ACT_INSERT, 31'(k)));
        end
        send(make_cmd(ACT_INSERT, 31'd99));
        send(make_cmd(ACT_SORT, 31'd0));
        send(make_cmd(ACT_LIST, 31'd0));
        send(make_cmd(ACT_DELETE, 31'd0));
        send(make_cmd(ACT_DELETE, 31'd1234));
        send(make_cmd(ACT_DELETE, 31'h7fffffff));
        send_idle_end();

        // long receiver hold-off while commands keep coming
        hold_off = 1'b1;
        fork
            begin
                for (int k = 0; k < 2000 && hold_off; k++) begin
                    @(posedge i_clk);
                end
                hold_off = 1'b0;
            end
            random_phase(10);
        join

        random_phase(10);
        send_idle_pct = 74;
        random_phase(35);
        send_idle_pct = 0; recv_stall_pct = 74;
        random_phase(35);
        send_idle_pct = 35; recv_stall_pct = 35;
        random_phase(35);

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("keyed_record_table_insert_delete_sort_unit_test passed");
        end else begin
            $display("keyed_record_table_insert_delete_sort_unit_test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
